>>> rtl/core/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants shared by the software timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

  // operation codes of a command
  typedef enum logic [1:0] {
    OP_OVERFLOW = 2'd0,
    OP_START    = 2'd1,
    OP_STOP     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  // status codes of a reply
  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_NOINIT = 3'd1,
    STAT_NULLID = 3'd2,
    STAT_EMPTY  = 3'd3,
    STAT_FULL   = 3'd4
  } status_t;

  // kind of a result
  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_FIRED  = 1'b1
  } kind_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVF_PER_TICK  = 1'd1;

  // command payload
  typedef struct packed {
    op_t         operation;
    logic [7:0]  task_id;
    logic [15:0] delay_ticks;
    logic        periodic;
  } cmd_t;

  // result payload
  typedef struct packed {
    kind_t       result_kind;
    status_t     status;
    logic [7:0]  fired_id;
    logic        last;
  } rsp_t;

  // one timer entry as stored in the table memory
  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] delay;
    logic [15:0] elapsed;
    logic        periodic;
  } entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_TAIL,
    S_MOVE,
    S_REPLY
  } state_t;

endpackage

>>> rtl/core/software_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_table
// Compact table of software timers with start, stop, clear and tick handling.
// ----------------------------------------------------------------------------
// Timers live in a single-port-write, registered-read memory of MAX_TASKS
// entries; a sequencer reads, updates and writes back one entry at a time.
// Start, clear and an overflow event that makes no tick go from accept
// straight to the status reply. A stop walks the table until the first
// matching id, then moves the last entry into the freed slot unless the match
// is the last entry. A tick steps through the entries present when it starts:
// an entry moved into a freed slot is not looked at again, and the move of a
// one-shot timer's replacement gives it the increment that visit would have.
// While a result waits on a stalled output the sequencer holds for as long as
// the stall lasts. Every command ends with exactly one status reply carrying
// last; fired results of a tick come before it in table order.
module software_timer_table #(
  parameter int MAX_TASKS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [stt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stt_pkg::CFG_DATA_W-1:0]  cfg_data,
  // command channel
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  stt_pkg::cmd_t                   cmd,
  // result channel
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output stt_pkg::rsp_t                   rsp
);

  import stt_pkg::*;

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  // configuration registers
  logic       enabled;
  logic [7:0] ovf_per_tick;

  // control state
  state_t        state, state_next;
  op_t           op_r, op_next;
  logic [7:0]    id_r, id_next;
  status_t       status_r, status_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [7:0]    ovf_count, ovf_next;

  // table memory
  entry_t        mem [MAX_TASKS];
  entry_t        rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  // result staging
  logic          emit;
  rsp_t          emit_data;
  logic          out_free;

  // helpers
  logic [CW-1:0] tail;
  logic [CW-1:0] idx_plus;
  logic [15:0]   elapsed_inc;
  logic          fire;
  logic [7:0]    ovf_inc;

  assign tail        = count - CW'(1);
  assign idx_plus    = idx + CW'(1);
  assign elapsed_inc = (rd_data.elapsed == 16'hFFFF) ? rd_data.elapsed
                                                     : rd_data.elapsed + 16'd1;
  assign fire        = (elapsed_inc >= rd_data.delay);
  assign ovf_inc     = ovf_count + 8'd1;
  assign out_free    = !rsp_valid || !rsp_stall;
  assign cmd_stall   = (state != S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      ovf_per_tick <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED:      enabled      <= cfg_data[0];
        REG_OVF_PER_TICK: ovf_per_tick <= cfg_data;
        default: ;
      endcase
    end
  end

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf_count <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf_count <= ovf_next;
    end
    op_r     <= op_next;
    id_r     <= id_next;
    status_r <= status_next;
    idx      <= idx_next;
  end

  // next state, memory accesses and results
  always_comb begin
    state_next  = state;
    op_next     = op_r;
    id_next     = id_r;
    status_next = status_r;
    count_next  = count;
    idx_next    = idx;
    ovf_next    = ovf_count;
    rd_en       = 1'b0;
    rd_addr     = idx[AW-1:0];
    mem_we      = 1'b0;
    mem_waddr   = idx[AW-1:0];
    mem_wdata   = rd_data;
    emit        = 1'b0;
    emit_data   = '0;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          op_next     = cmd.operation;
          id_next     = cmd.task_id;
          idx_next    = '0;
          status_next = STAT_OK;
          state_next  = S_REPLY;
          case (cmd.operation)
            OP_OVERFLOW: begin
              if (ovf_inc == ovf_per_tick) begin
                ovf_next = '0;
                if (count != '0) begin
                  state_next = S_READ;
                end
              end else begin
                ovf_next = ovf_inc;
              end
            end
            OP_START: begin
              if (!enabled) begin
                status_next = STAT_NOINIT;
              end else if (cmd.task_id == 8'd0) begin
                status_next = STAT_NULLID;
              end else if (count >= CW'(MAX_TASKS)) begin
                status_next = STAT_FULL;
              end else begin
                mem_we             = 1'b1;
                mem_waddr          = count[AW-1:0];
                mem_wdata.task_id  = cmd.task_id;
                mem_wdata.delay    = cmd.delay_ticks;
                mem_wdata.elapsed  = '0;
                mem_wdata.periodic = cmd.periodic;
                count_next         = count + CW'(1);
              end
            end
            OP_STOP: begin
              if (!enabled) begin
                status_next = STAT_NOINIT;
              end else if (count == '0) begin
                status_next = STAT_EMPTY;
              end else begin
                state_next = S_READ;
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            default: ;
          endcase
        end
      end

      // fetch the entry at idx
      S_READ: begin
        rd_en      = 1'b1;
        rd_addr    = idx[AW-1:0];
        state_next = S_EVAL;
      end

      // look at the fetched entry
      S_EVAL: begin
        if (op_r == OP_STOP) begin
          if (rd_data.task_id == id_r) begin
            if (idx == tail) begin
              count_next = tail;
              state_next = S_REPLY;
            end else begin
              state_next = S_TAIL;
            end
          end else if (idx_plus < count) begin
            idx_next   = idx_plus;
            state_next = S_READ;
          end else begin
            state_next = S_REPLY;
          end
        end else if (!fire) begin
          // no fire: store the incremented count and move on
          mem_we            = 1'b1;
          mem_wdata.elapsed = elapsed_inc;
          if (idx_plus < count) begin
            idx_next   = idx_plus;
            state_next = S_READ;
          end else begin
            state_next = S_REPLY;
          end
        end else if (out_free) begin
          emit                  = 1'b1;
          emit_data.result_kind = KIND_FIRED;
          emit_data.status      = STAT_OK;
          emit_data.fired_id    = rd_data.task_id;
          emit_data.last        = 1'b0;
          if (rd_data.periodic) begin
            mem_we            = 1'b1;
            mem_wdata.elapsed = '0;
            if (idx_plus < count) begin
              idx_next   = idx_plus;
              state_next = S_READ;
            end else begin
              state_next = S_REPLY;
            end
          end else if (idx == tail) begin
            count_next = tail;
            state_next = S_REPLY;
          end else begin
            state_next = S_TAIL;
          end
        end
      end

      // fetch the last entry to fill the freed slot
      S_TAIL: begin
        rd_en      = 1'b1;
        rd_addr    = tail[AW-1:0];
        state_next = S_MOVE;
      end

      // write the last entry into the freed slot; a tick still owes it the increment
      S_MOVE: begin
        mem_we = 1'b1;
        if (op_r == OP_OVERFLOW) begin
          mem_wdata.elapsed = elapsed_inc;
        end
        count_next = tail;
        if (op_r == OP_STOP) begin
          state_next = S_REPLY;
        end else if (idx_plus < tail) begin
          idx_next   = idx_plus;
          state_next = S_READ;
        end else begin
          state_next = S_REPLY;
        end
      end

      // closing status reply
      S_REPLY: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_data.result_kind = KIND_STATUS;
          emit_data.status      = status_r;
          emit_data.fired_id    = '0;
          emit_data.last        = 1'b1;
          state_next            = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (emit) begin
      rsp <= emit_data;
    end
  end

endmodule
